### hw/rtl/lphs_pkg.sv
`timescale 1ns / 1ps

package lphs_pkg;

  localparam int KEY_W   = 60;
  localparam int VAL_W   = 61;
  localparam int SLOT_W  = 10;
  localparam int ROW_W   = 32;
  localparam int ROW_LG  = 5;
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = KEY_W / DIGIT_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic mod_step;
    logic rd_home;
    logic rd_next;
    logic commit;
    logic load_out;
    logic out_full;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic mod_done;
    logic is_read;
    logic is_full;
    logic found;
  } sts_t;

endpackage

### hw/rtl/lphs_ram.sv
`timescale 1ns / 1ps

module lphs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/lphs_datapath.sv
`timescale 1ns / 1ps

module lphs_datapath #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lphs_pkg::ctl_t                         ctl,
  output lphs_pkg::sts_t                         sts,
  input  logic                                   in_cmd,
  input  logic [lphs_pkg::KEY_W-1:0]             in_key,
  output logic signed [lphs_pkg::VAL_W-1:0]      read_value,
  output logic [lphs_pkg::SLOT_W-1:0]            slot,
  output logic                                   table_full
);

  localparam int SW   = $clog2(TABLE_SIZE);
  localparam int ROWS = (TABLE_SIZE + lphs_pkg::ROW_W - 1) / lphs_pkg::ROW_W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int HW   = RW + lphs_pkg::ROW_LG;
  localparam int FW   = $clog2(TABLE_SIZE + 1);
  localparam bit POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

  logic                          cmd_q;
  logic [lphs_pkg::KEY_W-1:0]    key_q;
  logic [RW-1:0]                 clr_row;
  logic [FW-1:0]                 fill_count;
  logic [RW-1:0]                 cur_row;
  logic                          first;
  logic [HW-1:0]                 hit_slot;

  logic [HW-1:0]                 home;
  logic                          mod_done;
  logic [RW-1:0]                 home_row;
  logic [lphs_pkg::ROW_LG-1:0]   home_bit;
  logic [RW-1:0]                 next_row;

  logic [lphs_pkg::ROW_W-1:0]    occ_q;
  logic [lphs_pkg::ROW_W-1:0]    eligible;
  logic [lphs_pkg::ROW_LG-1:0]   free_idx;
  logic [HW-1:0]                 free_slot;
  logic                          found;

  logic                          occ_we;
  logic [RW-1:0]                 occ_waddr;
  logic [lphs_pkg::ROW_W-1:0]    occ_wdata;
  logic                          occ_re;
  logic [RW-1:0]                 occ_raddr;
  logic [lphs_pkg::KEY_W-1:0]    val_q;

  assign home_row = home[HW-1:lphs_pkg::ROW_LG];
  assign home_bit = home[lphs_pkg::ROW_LG-1:0];
  assign next_row = (cur_row == RW'(ROWS - 1)) ? '0 : cur_row + 1'b1;

  // home slot: plain mask for power-of-two sizes, else 4 key bits per cycle
  if (POW2) begin : g_mask
    assign home     = HW'(key_q[SW-1:0]);
    assign mod_done = 1'b1;
  end else begin : g_serial
    localparam int RMW = SW + lphs_pkg::DIGIT_W;
    localparam int CW  = $clog2(lphs_pkg::DIGITS + 1);

    logic [RMW-1:0]             rem;
    logic [RMW-1:0]             rem_next;
    logic [lphs_pkg::KEY_W-1:0] key_sh;
    logic [CW-1:0]              cnt;

    always_comb begin
      rem_next = {rem[SW-1:0], key_sh[lphs_pkg::KEY_W-1 -: lphs_pkg::DIGIT_W]};
      for (int k = lphs_pkg::DIGIT_W - 1; k >= 0; k--) begin
        if (rem_next >= RMW'(TABLE_SIZE << k)) begin
          rem_next = rem_next - RMW'(TABLE_SIZE << k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cnt <= '0;
      end else if (ctl.capture) begin
        cnt <= '0;
      end else if (ctl.mod_step) begin
        cnt <= cnt + 1'b1;
      end
      if (ctl.capture) begin
        rem    <= '0;
        key_sh <= in_key;
      end else if (ctl.mod_step) begin
        rem    <= rem_next;
        key_sh <= key_sh << lphs_pkg::DIGIT_W;
      end
    end

    assign home     = HW'(rem[SW-1:0]);
    assign mod_done = (cnt == CW'(lphs_pkg::DIGITS));
  end

  // free slots in the current row; first visit skips bits below home
  always_comb begin
    for (int b = 0; b < lphs_pkg::ROW_W; b++) begin
      eligible[b] = !occ_q[b]
                    && ({1'b0, cur_row, lphs_pkg::ROW_LG'(b)} < (HW + 1)'(TABLE_SIZE))
                    && (!first || (lphs_pkg::ROW_LG'(b) >= home_bit));
    end
  end

  always_comb begin
    free_idx = '0;
    for (int b = lphs_pkg::ROW_W - 1; b >= 0; b--) begin
      if (eligible[b]) begin
        free_idx = lphs_pkg::ROW_LG'(b);
      end
    end
  end

  assign found     = |eligible;
  assign free_slot = {cur_row, free_idx};

  always_comb begin
    occ_we    = ctl.clr_step || ctl.commit;
    occ_waddr = ctl.clr_step ? clr_row : cur_row;
    occ_wdata = ctl.clr_step ? '0
                             : (occ_q | (lphs_pkg::ROW_W'(1) << free_idx));
    occ_re    = ctl.rd_home || ctl.rd_next;
    occ_raddr = ctl.rd_home ? home_row : next_row;
  end

  lphs_ram #(
    .WIDTH(lphs_pkg::ROW_W),
    .DEPTH(ROWS)
  ) u_occ_ram (
    .clk  (clk),
    .we   (occ_we),
    .waddr(occ_waddr),
    .wdata(occ_wdata),
    .re   (occ_re),
    .raddr(occ_raddr),
    .rdata(occ_q)
  );

  lphs_ram #(
    .WIDTH(lphs_pkg::KEY_W),
    .DEPTH(TABLE_SIZE)
  ) u_val_ram (
    .clk  (clk),
    .we   (ctl.commit),
    .waddr(SW'(free_slot)),
    .wdata(key_q),
    .re   (ctl.rd_home),
    .raddr(SW'(home)),
    .rdata(val_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row    <= '0;
      fill_count <= '0;
    end else begin
      if (ctl.clr_step) begin
        clr_row <= clr_row + 1'b1;
      end
      if (ctl.commit) begin
        fill_count <= fill_count + 1'b1;
      end
    end
    if (ctl.capture) begin
      cmd_q <= in_cmd;
      key_q <= in_key;
    end
    if (ctl.rd_home) begin
      cur_row  <= home_row;
      first    <= 1'b1;
      hit_slot <= home;
    end else if (ctl.rd_next) begin
      cur_row <= next_row;
      first   <= 1'b0;
    end else if (ctl.commit) begin
      hit_slot <= free_slot;
    end
    if (ctl.load_out) begin
      table_full <= ctl.out_full;
      slot       <= ctl.out_full ? '0 : lphs_pkg::SLOT_W'(hit_slot);
      if (ctl.out_full || cmd_q == lphs_pkg::CMD_INSERT) begin
        read_value <= '0;
      end else if (occ_q[hit_slot[lphs_pkg::ROW_LG-1:0]]) begin
        read_value <= {1'b0, val_q};
      end else begin
        read_value <= '1;
      end
    end
  end

  always_comb begin
    sts.clr_done = (clr_row == RW'(ROWS - 1));
    sts.mod_done = mod_done;
    sts.is_read  = (cmd_q == lphs_pkg::CMD_READ);
    sts.is_full  = (fill_count == FW'(TABLE_SIZE));
    sts.found    = found;
  end

endmodule

### hw/rtl/lphs_ctrl.sv
`timescale 1ns / 1ps

module lphs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lphs_pkg::ctl_t ctl,
  input  lphs_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_EVAL,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   full_q;
  logic   full_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    ctl        = '0;
    state_next = state;
    full_next  = full_q;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.capture = 1'b1;
          full_next   = 1'b0;
          state_next  = S_MOD;
        end
      end
      S_MOD: begin
        if (!sts.mod_done) begin
          ctl.mod_step = 1'b1;
        end else if (!sts.is_read && sts.is_full) begin
          full_next  = 1'b1;
          state_next = S_FIN;
        end else begin
          ctl.rd_home = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        // inserts scan one occupancy row per cycle until a free slot shows up; reads go straight to S_FIN
        if (sts.is_read) begin
          state_next = S_FIN;
        end else if (sts.found) begin
          ctl.commit = 1'b1;
          state_next = S_FIN;
        end else begin
          ctl.rd_next = 1'b1;
        end
      end
      S_FIN: begin
        ctl.out_full = full_q;
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      full_q    <= 1'b0;
    end else begin
      state  <= state_next;
      full_q <= full_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/linear_probe_hash_store.sv
`timescale 1ns / 1ps

// Linear-probing hash store of TABLE_SIZE slots holding 60-bit values. Insert
// (cmd 0) places key in the first free slot at or above key mod TABLE_SIZE,
// wrapping at the top, and returns that slot; read (cmd 1) returns the value in
// the home slot, or -1 if it was never written. An insert into a full table
// writes nothing and returns table_full with zero slot and value. One request
// is in flight at a time. A read, or an insert whose free slot lies in the
// home slot's 32-slot occupancy row, steps through S_MOD, S_EVAL and S_FIN
// before its result is registered, and the block is back in S_IDLE as the
// result is presented; each further row scanned adds another occupancy read
// in S_EVAL, since the occupancy memory yields one 32-bit row per read. A
// result held by a stalled consumer holds off the next request. For a
// TABLE_SIZE that is not a power of two the home slot is reduced 4 key bits
// per cycle in S_MOD before each request goes on. After reset a clearing pass
// writes every occupancy row to zero, and in_ready stays low until it is done.
module linear_probe_hash_store #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic [lphs_pkg::KEY_W-1:0]         key,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [lphs_pkg::VAL_W-1:0]  read_value,
  output logic [lphs_pkg::SLOT_W-1:0]        slot,
  output logic                               table_full
);

  lphs_pkg::ctl_t ctl;
  lphs_pkg::sts_t sts;

  lphs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl),
    .sts      (sts)
  );

  lphs_datapath #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_cmd    (cmd),
    .in_key    (key),
    .read_value(read_value),
    .slot      (slot),
    .table_full(table_full)
  );

  a_full_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && table_full) |-> (read_value == '0 && slot == '0))
    else $error("full-table result carries nonzero slot or value");

  a_commit_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> !sts.is_full)
    else $error("slot committed while table is full");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    ctl.capture |=> !in_ready)
    else $error("new request taken while one is in flight");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SLOTS       = 1024;
  localparam int RANDOM_REQS = 800;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    logic signed [lphs_pkg::VAL_W-1:0] read_value;
    logic [lphs_pkg::SLOT_W-1:0]       slot;
    logic                              table_full;
  } result_t;

  // Tracks table contents and the results still owed by the block.
  class hash_store_scoreboard;
    bit                         occupied [SLOTS];
    logic [lphs_pkg::KEY_W-1:0] stored [SLOTS];
    int                         fill;
    int                         errors;
    result_t                    pending_results [$];

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR: %s got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void note_request(logic op, logic [lphs_pkg::KEY_W-1:0] k);
      result_t r;
      int home;
      int pos;
      home = int'(k[lphs_pkg::SLOT_W-1:0]);
      r = '0;
      if (op == lphs_pkg::CMD_READ) begin
        r.slot = k[lphs_pkg::SLOT_W-1:0];
        r.read_value = occupied[home] ? {1'b0, stored[home]} : '1;
      end else if (fill >= SLOTS) begin
        r.table_full = 1'b1;
      end else begin
        pos = home;
        while (occupied[pos]) pos = (pos + 1) % SLOTS;
        occupied[pos] = 1'b1;
        stored[pos] = k;
        fill++;
        r.slot = lphs_pkg::SLOT_W'(pos);
      end
      pending_results.push_back(r);
    endfunction

    task check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result with none pending, slot", 64'(got.slot), '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value)
        report("read_value", 64'(got.read_value), 64'(want.read_value));
      if (got.slot !== want.slot)
        report("slot", 64'(got.slot), 64'(want.slot));
      if (got.table_full !== want.table_full)
        report("table_full", 64'(got.table_full), 64'(want.table_full));
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = lphs_pkg::CMD_INSERT;
  logic [lphs_pkg::KEY_W-1:0] key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [lphs_pkg::VAL_W-1:0] read_value;
  logic [lphs_pkg::SLOT_W-1:0] slot;
  logic table_full;

  hash_store_scoreboard sb = new();
  logic [lphs_pkg::KEY_W-1:0] inserted_keys [$];
  bit sender_calm;
  bit sink_calm;
  int cycles;

  linear_probe_hash_store uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .key(key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .slot(slot),
    .table_full(table_full)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [lphs_pkg::KEY_W-1:0] make_key();
    logic [63:0] raw;
    logic [lphs_pkg::KEY_W-1:0] k;
    int pick;
    int base;
    raw = {$urandom, $urandom};
    k = raw[lphs_pkg::KEY_W-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // fully random home slot
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0: base = 0;
        1: base = 30;
        2: base = 500;
        default: base = 1000;
      endcase
      k[lphs_pkg::SLOT_W-1:0] =
        lphs_pkg::SLOT_W'((base + $urandom_range(0, 40)) % SLOTS);
    end else if (pick < 75) begin
      k[lphs_pkg::SLOT_W-1:0] = lphs_pkg::SLOT_W'($urandom_range(1010, SLOTS - 1));
    end else if (pick < 88) begin
      k[lphs_pkg::KEY_W-1:lphs_pkg::SLOT_W] = $urandom_range(0, 1) ? '1 : '0;
    end else if (inserted_keys.size() > 0) begin
      k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
    end
    return k;
  endfunction

  task automatic send_request(input logic op, input logic [lphs_pkg::KEY_W-1:0] k);
    int gap;
    bit ready_seen;
    gap = sender_calm ? 0 : (($urandom_range(0, 2) == 0) ? pick_gap() : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    key <= k;
    do begin
      @(negedge clk);
      ready_seen = (in_ready === 1'b1);
      @(posedge clk);
    end while (!ready_seen);
    sb.note_request(op, k);
    if (op == lphs_pkg::CMD_INSERT) inserted_keys.push_back(k);
  endtask

  task automatic send_random_request();
    logic [lphs_pkg::KEY_W-1:0] k;
    k = make_key();
    if ($urandom_range(0, 3) != 0) begin
      send_request(lphs_pkg::CMD_INSERT, k);
    end else begin
      if (inserted_keys.size() > 0 && $urandom_range(0, 1) == 0)
        k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
      send_request(lphs_pkg::CMD_READ, k);
    end
  endtask

  initial begin : sink
    bit fire;
    result_t got;
    int stall_left;
    int tick;
    stall_left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      fire = (out_valid === 1'b1) && out_ready;
      got = {read_value, slot, table_full};
      @(posedge clk);
      if (fire) sb.check_result(got);
      tick++;
      if (tick % 200 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!sink_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // free slot, both ends of the key range, wraparound past the top slot
    send_request(lphs_pkg::CMD_READ, '0);
    send_request(lphs_pkg::CMD_INSERT, '0);
    send_request(lphs_pkg::CMD_INSERT, '1);
    send_request(lphs_pkg::CMD_INSERT, '1);
    send_request(lphs_pkg::CMD_INSERT, {{25{2'b10}}, 10'd1023});
    send_request(lphs_pkg::CMD_READ, '0);
    send_request(lphs_pkg::CMD_READ, '1);
    send_request(lphs_pkg::CMD_READ,
                 {{(lphs_pkg::KEY_W - lphs_pkg::SLOT_W){1'b1}}, 10'd1});
    send_request(lphs_pkg::CMD_READ,
                 {{(lphs_pkg::KEY_W - lphs_pkg::SLOT_W){1'b0}}, 10'd2});
    // cluster that runs across an occupancy row boundary, with duplicates
    send_request(lphs_pkg::CMD_INSERT, 60'd30);
    send_request(lphs_pkg::CMD_INSERT, {{25{2'b01}}, 10'd30});
    send_request(lphs_pkg::CMD_INSERT, 60'd30);
    send_request(lphs_pkg::CMD_INSERT, 60'd31);
    send_request(lphs_pkg::CMD_READ, 60'd32);
    send_request(lphs_pkg::CMD_READ, 60'd34);
    send_request(lphs_pkg::CMD_READ,
                 {{(lphs_pkg::KEY_W - lphs_pkg::SLOT_W){1'b1}}, 10'd500});
    send_request(lphs_pkg::CMD_INSERT,
                 {{(lphs_pkg::KEY_W - lphs_pkg::SLOT_W){1'b1}}, 10'd500});
    send_request(lphs_pkg::CMD_READ,
                 {{(lphs_pkg::KEY_W - lphs_pkg::SLOT_W){1'b0}}, 10'd500});

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      send_random_request();
    end

    // fill the rest of the table, then hit it while full
    while (sb.fill < SLOTS) send_request(lphs_pkg::CMD_INSERT, make_key());
    repeat (24)
      send_request($urandom_range(0, 1) ? lphs_pkg::CMD_READ : lphs_pkg::CMD_INSERT,
                   make_key());
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
